// File: hw/rtl/keyed_timeout_table_unit_assert.svh
// ----------------------------------------------------------------------------
// Keyed timeout table assertion macros
// Concurrent check wrappers clocked on i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef KEYED_TIMEOUT_TABLE_UNIT_ASSERT_SVH
`define KEYED_TIMEOUT_TABLE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every edge out of reset
`define KTTU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define KTTU_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define KTTU_ASSERT(lbl, prop, msg)
`define KTTU_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: hw/rtl/kttu_pkg.sv
// ----------------------------------------------------------------------------
// Keyed timeout table package
// Field widths, command and status codes, shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kttu_pkg;

    localparam int KEY_W  = 32;
    localparam int TIME_W = 32;
    localparam int TAG_W  = 16;
    localparam int CMD_W  = 3;
    localparam int STS_W  = 3;

    localparam int S_TDATA_W = 80;  // key, gap_ms, tag
    localparam int S_TUSER_W = 8;   // command
    localparam int M_TDATA_W = 48;  // result_key, result_tag
    localparam int M_TUSER_W = 8;   // status

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_TAG_BITS      = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET   = 3'd0,
        CMD_TAKE  = 3'd1,
        CMD_QUERY = 3'd2,
        CMD_TICK  = 3'd3,
        CMD_SWEEP = 3'd4
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_DUP       = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_FULL      = 3'd3,
        STS_EXPIRED   = 3'd4,
        STS_NONE      = 3'd5
    } t_status;

    // compare unit flags for one table entry
    typedef struct packed {
        logic eq;       // entry key equals search key
        logic expired;  // elapsed time beyond gap
        logic less;     // entry key below current best key
    } t_cmp_res;

    // table update strobes
    typedef struct packed {
        logic wr_en;    // write entry and mark valid
        logic clr_en;   // drop entry
    } t_store_ctl;

endpackage

// File: hw/rtl/kttu_store.sv
// ----------------------------------------------------------------------------
// Keyed timeout table entry store
// Entry memory with one registered read port, one write port, valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kttu_store #(
    parameter int TABLE_ENTRIES = kttu_pkg::DEF_TABLE_ENTRIES,
    parameter int TAG_STORE_W   = kttu_pkg::TAG_W
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kttu_pkg::t_store_ctl                  i_ctl,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]      i_rd_addr,
    output logic                                  o_rd_vld,
    output logic [kttu_pkg::KEY_W-1:0]            o_rd_key,
    output logic [kttu_pkg::TIME_W-1:0]           o_rd_start,
    output logic [kttu_pkg::TIME_W-1:0]           o_rd_gap,
    output logic [TAG_STORE_W-1:0]                o_rd_tag,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]      i_wr_addr,
    input  logic [kttu_pkg::KEY_W-1:0]            i_wr_key,
    input  logic [kttu_pkg::TIME_W-1:0]           i_wr_start,
    input  logic [kttu_pkg::TIME_W-1:0]           i_wr_gap,
    input  logic [TAG_STORE_W-1:0]                i_wr_tag,
    input  logic [$clog2(TABLE_ENTRIES)-1:0]      i_clr_addr
);
    import kttu_pkg::*;

    logic [KEY_W-1:0]       r_key_mem   [TABLE_ENTRIES];
    logic [TIME_W-1:0]      r_start_mem [TABLE_ENTRIES];
    logic [TIME_W-1:0]      r_gap_mem   [TABLE_ENTRIES];
    logic [TAG_STORE_W-1:0] r_tag_mem   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TABLE_ENTRIES-1:0] n_valid;
    logic                     r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_key_mem[i_wr_addr]   <= i_wr_key;
            r_start_mem[i_wr_addr] <= i_wr_start;
            r_gap_mem[i_wr_addr]   <= i_wr_gap;
            r_tag_mem[i_wr_addr]   <= i_wr_tag;
        end
        o_rd_key   <= r_key_mem[i_rd_addr];
        o_rd_start <= r_start_mem[i_rd_addr];
        o_rd_gap   <= r_gap_mem[i_rd_addr];
        o_rd_tag   <= r_tag_mem[i_rd_addr];
    end

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.wr_en) begin
            n_valid[i_wr_addr] = 1'b1;
        end
        if (i_ctl.clr_en) begin
            n_valid[i_clr_addr] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_rd_vld <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_vld = r_rd_vld;

endmodule

// File: hw/rtl/kttu_cmp.sv
// ----------------------------------------------------------------------------
// Keyed timeout table compare unit
// Shared per-entry compare: key match, expiry, key ordering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kttu_cmp (
    input  logic [kttu_pkg::KEY_W-1:0]  i_rd_key,
    input  logic [kttu_pkg::TIME_W-1:0] i_rd_start,
    input  logic [kttu_pkg::TIME_W-1:0] i_rd_gap,
    input  logic [kttu_pkg::TIME_W-1:0] i_now,
    input  logic [kttu_pkg::KEY_W-1:0]  i_key,
    input  logic [kttu_pkg::KEY_W-1:0]  i_best_key,
    output kttu_pkg::t_cmp_res          o_res
);
    import kttu_pkg::*;

    logic [TIME_W-1:0] elapsed;

    // elapsed time wraps with the counter
    assign elapsed       = i_now - i_rd_start;
    assign o_res.eq      = (i_rd_key == i_key);
    assign o_res.expired = (elapsed > i_rd_gap);
    assign o_res.less    = (i_rd_key < i_best_key);

endmodule

// File: hw/rtl/keyed_timeout_table_unit.sv
// ----------------------------------------------------------------------------
// Keyed timeout table unit
// Bounded table of pending timeouts keyed by sequence number, with set,
// take, query, millisecond tick and expiry sweep commands.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)          | tuser       | tlast
//  s_axis  | in  | key, gap_ms, tag            | command     | -
//  m_axis  | out | result_key, result_tag      | status      | last
//
//  A sweep removing k entries takes max(k,1) table passes; every table pass
//  reads one entry per cycle through the single memory read port and the
//  shared compare unit.
//  Reset: i_rst_n synchronous active low clears valid flags and the counter.
//  Output stalls hold the sequencer in its emit step; ready only when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyed_timeout_table_unit_assert.svh"

module keyed_timeout_table_unit #(
    parameter int TABLE_ENTRIES = kttu_pkg::DEF_TABLE_ENTRIES,
    parameter int TAG_BITS      = kttu_pkg::DEF_TAG_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] key, [63:32] gap_ms, [79:64] tag
    input  logic [kttu_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [2:0] command
    input  logic [kttu_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] result_key, [47:32] result_tag
    output logic [kttu_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [2:0] status
    output logic [kttu_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                             m_axis_tlast
);
    import kttu_pkg::*;

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int CW   = AW + 1;
    localparam int TagW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [TIME_W-1:0] r_gap, n_gap;
    logic [TagW-1:0]   r_tag, n_tag;
    logic [TIME_W-1:0] r_now, n_now;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_sel_found, n_sel_found;
    logic [AW-1:0]     r_sel_idx, n_sel_idx;
    logic [KEY_W-1:0]  r_sel_key, n_sel_key;
    logic [TagW-1:0]   r_sel_tag, n_sel_tag;
    logic              r_free_found, n_free_found;
    logic [AW-1:0]     r_free_idx, n_free_idx;
    logic [CW-1:0]     r_exp_cnt, n_exp_cnt;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [KEY_W-1:0]  r_out_key, n_out_key;
    logic [TAG_W-1:0]  r_out_tag, n_out_tag;
    logic              r_out_last, n_out_last;

    logic [CMD_W-1:0]  in_cmd;
    logic              out_free;
    logic [AW-1:0]     eval_idx;
    t_store_ctl        store_ctl;
    logic              rd_vld;
    logic [KEY_W-1:0]  rd_key;
    logic [TIME_W-1:0] rd_start;
    logic [TIME_W-1:0] rd_gap;
    logic [TagW-1:0]   rd_tag;
    t_cmp_res          cmp;

    kttu_store #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TAG_STORE_W   (TagW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (store_ctl),
        .i_rd_addr  (r_cnt[AW-1:0]),
        .o_rd_vld   (rd_vld),
        .o_rd_key   (rd_key),
        .o_rd_start (rd_start),
        .o_rd_gap   (rd_gap),
        .o_rd_tag   (rd_tag),
        .i_wr_addr  (r_free_idx),
        .i_wr_key   (r_key),
        .i_wr_start (r_now),
        .i_wr_gap   (r_gap),
        .i_wr_tag   (r_tag),
        .i_clr_addr (r_sel_idx)
    );

    kttu_cmp u_cmp (
        .i_rd_key   (rd_key),
        .i_rd_start (rd_start),
        .i_rd_gap   (rd_gap),
        .i_now      (r_now),
        .i_key      (r_key),
        .i_best_key (r_sel_key),
        .o_res      (cmp)
    );

    assign in_cmd   = s_axis_tuser[CMD_W-1:0];
    // output register frees this cycle if empty or being taken
    assign out_free = !r_out_valid || m_axis_tready;
    // read data belongs to the address issued in the previous cycle
    assign eval_idx = AW'(r_cnt - CW'(1));

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_gap        = r_gap;
        n_tag        = r_tag;
        n_now        = r_now;
        n_cnt        = r_cnt;
        n_sel_found  = r_sel_found;
        n_sel_idx    = r_sel_idx;
        n_sel_key    = r_sel_key;
        n_sel_tag    = r_sel_tag;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_exp_cnt    = r_exp_cnt;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_tag    = r_out_tag;
        n_out_last   = r_out_last;
        store_ctl    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd        = t_cmd'(in_cmd);
                    n_key        = s_axis_tdata[31:0];
                    n_gap        = s_axis_tdata[63:32];
                    n_tag        = s_axis_tdata[64 +: TagW];
                    n_cnt        = '0;
                    n_sel_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_exp_cnt    = '0;
                    unique case (in_cmd)
                        CMD_SET, CMD_TAKE, CMD_QUERY, CMD_SWEEP: n_state = S_SCAN;
                        CMD_TICK: n_state = S_EMIT;
                        default:  n_state = S_IDLE;  // unused codes dropped
                    endcase
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt != '0) begin
                    if (r_cmd == CMD_SWEEP) begin
                        // lowest expired key of this pass
                        if (rd_vld && cmp.expired) begin
                            n_exp_cnt = r_exp_cnt + CW'(1);
                            if (!r_sel_found || cmp.less) begin
                                n_sel_found = 1'b1;
                                n_sel_idx   = eval_idx;
                                n_sel_key   = rd_key;
                                n_sel_tag   = rd_tag;
                            end
                        end
                    end else begin
                        if (rd_vld && cmp.eq) begin
                            n_sel_found = 1'b1;
                            n_sel_idx   = eval_idx;
                            n_sel_tag   = rd_tag;
                        end
                        // first free slot
                        if (!rd_vld && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = eval_idx;
                        end
                    end
                end
                if (r_cnt == CW'(TABLE_ENTRIES)) begin
                    n_cnt   = r_cnt;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = '0;
                    n_out_tag    = '0;
                    n_out_last   = 1'b1;
                    n_out_status = STS_OK;
                    n_state      = S_IDLE;
                    unique case (r_cmd)
                        CMD_SET: begin
                            n_out_key = r_key;
                            if (r_sel_found) begin
                                n_out_status = STS_DUP;
                            end else if (r_free_found) begin
                                store_ctl.wr_en = 1'b1;
                            end else begin
                                n_out_status = STS_FULL;
                            end
                        end
                        CMD_TAKE: begin
                            n_out_key = r_key;
                            if (r_sel_found) begin
                                n_out_tag        = TAG_W'(r_sel_tag);
                                store_ctl.clr_en = 1'b1;
                            end else begin
                                n_out_status = STS_NOT_FOUND;
                            end
                        end
                        CMD_QUERY: begin
                            n_out_key = r_key;
                            if (!r_sel_found) begin
                                n_out_status = STS_NOT_FOUND;
                            end
                        end
                        CMD_TICK: begin
                            n_now = r_now + TIME_W'(1);
                        end
                        CMD_SWEEP: begin
                            if (r_sel_found) begin
                                n_out_status     = STS_EXPIRED;
                                n_out_key        = r_sel_key;
                                n_out_tag        = TAG_W'(r_sel_tag);
                                n_out_last       = (r_exp_cnt == CW'(1));
                                store_ctl.clr_en = 1'b1;
                                if (r_exp_cnt != CW'(1)) begin
                                    // more expired entries: rescan
                                    n_state     = S_SCAN;
                                    n_cnt       = '0;
                                    n_sel_found = 1'b0;
                                    n_exp_cnt   = '0;
                                end
                            end else begin
                                n_out_status = STS_NONE;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && !m_axis_tready;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_now       <= '0;
            r_exp_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_exp_cnt   <= n_exp_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_gap        <= n_gap;
        r_tag        <= n_tag;
        r_cnt        <= n_cnt;
        r_sel_found  <= n_sel_found;
        r_sel_idx    <= n_sel_idx;
        r_sel_key    <= n_sel_key;
        r_sel_tag    <= n_sel_tag;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_tag    <= n_out_tag;
        r_out_last   <= n_out_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_tag, r_out_key};
    assign m_axis_tuser  = {{(M_TUSER_W - STS_W){1'b0}}, r_out_status};
    assign m_axis_tlast  = r_out_last;

    // only expired words may be followed by more words of the same sweep
    `KTTU_ASSERT(a_mid_word_expired, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2:0] == STS_EXPIRED, "non-last word is not an expired report")
    // scan pointer stays within the table
    `KTTU_ASSERT(a_scan_bound, r_state == S_SCAN |-> r_cnt <= CW'(TABLE_ENTRIES), "scan counter past table end")
    // a tick emitted advances the millisecond counter by one
    `KTTU_ASSERT(a_tick_advance, r_state == S_EMIT && r_cmd == CMD_TICK && out_free |=> r_now == $past(r_now) + TIME_W'(1), "tick did not advance counter")
    // expiry count never exceeds the entry count
    `KTTU_ASSERT_NEVER(a_exp_cnt_bound, r_exp_cnt > CW'(TABLE_ENTRIES), "expired count beyond table size")

endmodule
